### src/lcd_pkg.sv
// Shared types, constants and codes for the loop chunk dispenser.
`timescale 1ns / 1ps
`default_nettype none

package lcd_pkg;

   // Sizing of the loop index and of the worker pool.
   localparam int INDEX_BITS   = 32;
   localparam int MAX_WORKERS  = 64;
   localparam int WORKER_BITS  = $clog2(MAX_WORKERS + 1);
   localparam int ID_BITS      = 6;
   localparam int CHUNK_BITS   = 16;
   localparam int MODE_BITS    = 2;

   // The shared divider splits an index-wide count by twice the worker count at most.
   localparam int DIV_BITS     = WORKER_BITS + 1;
   localparam int STEP_BITS    = $clog2(INDEX_BITS);

   // Register file layout.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      CSR_SCHEDULE_MODE = 2'd0,
      CSR_MIN_CHUNK     = 2'd1,
      CSR_WORKER_COUNT  = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   // Schedule modes.
   localparam logic [MODE_BITS-1:0] MODE_STATIC  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DYNAMIC = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_GUIDED  = 2'd2;

   // Operation and status codes.
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_CLAIM = 1'b1;

   localparam logic [1:0] STATUS_GRANT  = 2'd0;
   localparam logic [1:0] STATUS_NONE   = 2'd1;
   localparam logic [1:0] STATUS_ACCEPT = 2'd2;
   localparam logic [1:0] STATUS_REJECT = 2'd3;

   typedef struct packed {
      logic                          op;
      logic signed [INDEX_BITS-1:0]  range_start;
      logic signed [INDEX_BITS-1:0]  range_end;
      logic [ID_BITS-1:0]            worker_id;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                    status;
      logic signed [INDEX_BITS-1:0]  chunk_begin;
      logic signed [INDEX_BITS-1:0]  chunk_end;
   } rsp_payload_type;

   // Divider command and result.
   typedef struct packed {
      logic                   start;
      logic [INDEX_BITS-1:0]  dividend;
      logic [DIV_BITS-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [INDEX_BITS-1:0]  quotient;
      logic [DIV_BITS-1:0]    remainder;
   } div_rsp_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_CHECK,
      STATE_DIVIDE,
      STATE_MULT,
      STATE_FINISH,
      STATE_DONE
   } state_type;

endpackage

`default_nettype wire

### src/loop_chunk_dispenser_unit.sv
// Loop chunk dispenser: hands out iteration ranges to workers under three schedules.
//
// A begin transaction on the req_ channel loads a new half-open range and rewinds
// the shared counter; a claim transaction returns one chunk for a worker. Each
// request produces exactly one response transaction on the rsp_ channel.
// The csr_ port holds schedule_mode (0x0), min_chunk (0x4) and worker_count (0x8);
// write it only while no request is in flight.
// Sequence: a begin request, or a claim answered with no work in CHECK, goes from
// CHECK straight to DONE. A dynamic claim passes CHECK, FINISH and DONE. Guided and
// static claims wait in DIVIDE on the shared restoring divider, which produces
// one quotient bit per cycle over the 32-bit index width; a static claim adds a MULT
// step for its offset before FINISH.
// One request is worked on at a time: req_ready is high only while the sequencer
// is idle, so a new request is taken only once the last one has left DONE.
// The response sits in an output register; a new request is accepted while a
// finished response still waits, and the next response waits until rsp_ready
// takes the previous one.
// Reset clears the range to the empty range at zero, sets the registers to
// static mode, one worker and chunk size one, and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module loop_chunk_dispenser_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire lcd_pkg::req_payload_type            req_payload,
   // Response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lcd_pkg::rsp_payload_type                 rsp_payload,
   // Register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lcd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [lcd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lcd_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                     csr_pready
);

   localparam int IW = lcd_pkg::INDEX_BITS;

   // Sequencer and request registers.
   lcd_pkg::state_type                  state_ff, state_in;
   logic                                op_ff, op_in;
   logic signed [IW-1:0]                start_ff, start_in;
   logic signed [IW-1:0]                end_ff, end_in;
   logic [lcd_pkg::ID_BITS-1:0]         worker_ff, worker_in;

   // Configuration registers.
   logic [lcd_pkg::MODE_BITS-1:0]       mode_ff, mode_in;
   logic [lcd_pkg::CHUNK_BITS-1:0]      min_chunk_ff, min_chunk_in;
   logic [lcd_pkg::WORKER_BITS-1:0]     workers_ff, workers_in;

   // Loop range state.
   logic signed [IW-1:0]                first_ff, first_in;
   logic signed [IW-1:0]                limit_ff, limit_in;
   logic signed [IW-1:0]                next_ff, next_in;

   // Work registers and result staging.
   logic [IW-1:0]                       prod_ff, prod_in;
   lcd_pkg::rsp_payload_type            res_ff, res_in;
   lcd_pkg::rsp_payload_type            rsp_ff, rsp_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   lcd_pkg::div_req_type                div_req;
   lcd_pkg::div_rsp_type                div_rsp;

   // Derived values.
   logic [lcd_pkg::WORKER_BITS-1:0]     eff_workers;
   logic [lcd_pkg::CHUNK_BITS-1:0]      eff_chunk;
   logic [IW-1:0]                       total;
   logic [IW-1:0]                       remaining;
   logic                                exhausted;
   logic                                id_in_range;
   logic                                extra_slot;
   logic [IW-1:0]                       extra_min;
   logic [IW-1:0]                       share_count;
   logic [IW-1:0]                       share_begin;
   logic [IW-1:0]                       share;
   logic [IW-1:0]                       chunk;
   logic [IW-1:0]                       chunk_stop;
   logic                                cfg_write;
   logic [1:0]                          cfg_index;

   lcd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Register port: writes complete in the access phase, reads are combinational.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = csr_paddr[3:2];

   always_comb begin
      mode_in      = mode_ff;
      min_chunk_in = min_chunk_ff;
      workers_in   = workers_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            lcd_pkg::CSR_SCHEDULE_MODE: mode_in      = csr_pwdata[lcd_pkg::MODE_BITS-1:0];
            lcd_pkg::CSR_MIN_CHUNK:     min_chunk_in = csr_pwdata[lcd_pkg::CHUNK_BITS-1:0];
            lcd_pkg::CSR_WORKER_COUNT:  workers_in   = csr_pwdata[lcd_pkg::WORKER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         lcd_pkg::CSR_SCHEDULE_MODE: csr_prdata = lcd_pkg::CSR_DATA_BITS'(mode_ff);
         lcd_pkg::CSR_MIN_CHUNK:     csr_prdata = lcd_pkg::CSR_DATA_BITS'(min_chunk_ff);
         lcd_pkg::CSR_WORKER_COUNT:  csr_prdata = lcd_pkg::CSR_DATA_BITS'(workers_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // Out-of-range register values are clamped to usable ones.
   always_comb begin
      if (workers_ff == '0) begin
         eff_workers = lcd_pkg::WORKER_BITS'(1);
      end else if (workers_ff > lcd_pkg::WORKER_BITS'(lcd_pkg::MAX_WORKERS)) begin
         eff_workers = lcd_pkg::WORKER_BITS'(lcd_pkg::MAX_WORKERS);
      end else begin
         eff_workers = workers_ff;
      end
      eff_chunk = (min_chunk_ff == '0) ? lcd_pkg::CHUNK_BITS'(1) : min_chunk_ff;
   end

   // Range arithmetic. A stored range never has its limit below its start, so the
   // differences fit unsigned in the index width.
   assign total       = IW'(limit_ff - first_ff);
   assign remaining   = IW'(limit_ff - next_ff);
   assign exhausted   = (next_ff >= limit_ff);
   assign id_in_range = ({1'b0, worker_ff} < eff_workers);

   // Static share: offset is id * base plus the leftover indices given to lower ids.
   always_comb begin
      extra_slot  = (IW'(worker_ff) < IW'(div_rsp.remainder));
      extra_min   = extra_slot ? IW'(worker_ff) : IW'(div_rsp.remainder);
      share_count = div_rsp.quotient + IW'(extra_slot);
      share_begin = IW'(first_ff) + prod_ff + extra_min;
   end

   // Dynamic and guided chunk: the larger of the chunk size and the guided share,
   // cut at the range limit.
   always_comb begin
      share = (mode_ff == lcd_pkg::MODE_GUIDED) ? div_rsp.quotient : '0;
      chunk = (share > IW'(eff_chunk)) ? share : IW'(eff_chunk);
      chunk_stop = (chunk >= remaining) ? IW'(limit_ff) : IW'(next_ff) + chunk;
   end

   // Sequencer: next state, work registers and divider commands.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      worker_in  = worker_ff;
      first_in   = first_ff;
      limit_in   = limit_ff;
      next_in    = next_ff;
      prod_in    = prod_ff;
      res_in     = res_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready  = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = total;
      div_req.divisor  = {1'b0, eff_workers};

      unique case (state_ff)
         lcd_pkg::STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_payload.op;
               start_in  = req_payload.range_start;
               end_in    = req_payload.range_end;
               worker_in = req_payload.worker_id;
               state_in  = lcd_pkg::STATE_CHECK;
            end
         end

         lcd_pkg::STATE_CHECK: begin
            res_in.status      = lcd_pkg::STATUS_NONE;
            res_in.chunk_begin = '0;
            res_in.chunk_end   = '0;
            state_in           = lcd_pkg::STATE_DONE;
            if (op_ff == lcd_pkg::OP_BEGIN) begin
               if (end_ff < start_ff) begin
                  res_in.status = lcd_pkg::STATUS_REJECT;
               end else begin
                  first_in      = start_ff;
                  limit_in      = end_ff;
                  next_in       = start_ff;
                  res_in.status = lcd_pkg::STATUS_ACCEPT;
               end
            end else begin
               unique case (mode_ff)
                  lcd_pkg::MODE_STATIC: begin
                     if (id_in_range && (total != '0)) begin
                        div_req.start = 1'b1;
                        state_in      = lcd_pkg::STATE_DIVIDE;
                     end
                  end
                  lcd_pkg::MODE_DYNAMIC: begin
                     if (!exhausted) begin
                        state_in = lcd_pkg::STATE_FINISH;
                     end
                  end
                  lcd_pkg::MODE_GUIDED: begin
                     if (!exhausted) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = remaining;
                        div_req.divisor  = {eff_workers, 1'b0};
                        state_in         = lcd_pkg::STATE_DIVIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         lcd_pkg::STATE_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = (mode_ff == lcd_pkg::MODE_STATIC) ? lcd_pkg::STATE_MULT
                                                            : lcd_pkg::STATE_FINISH;
            end
         end

         lcd_pkg::STATE_MULT: begin
            prod_in  = IW'(IW'(worker_ff) * div_rsp.quotient);
            state_in = lcd_pkg::STATE_FINISH;
         end

         lcd_pkg::STATE_FINISH: begin
            state_in = lcd_pkg::STATE_DONE;
            if (mode_ff == lcd_pkg::MODE_STATIC) begin
               if (share_count == '0) begin
                  res_in.status      = lcd_pkg::STATUS_NONE;
                  res_in.chunk_begin = '0;
                  res_in.chunk_end   = '0;
               end else begin
                  res_in.status      = lcd_pkg::STATUS_GRANT;
                  res_in.chunk_begin = share_begin;
                  res_in.chunk_end   = share_begin + share_count;
               end
            end else begin
               next_in            = chunk_stop;
               res_in.status      = lcd_pkg::STATUS_GRANT;
               res_in.chunk_begin = next_ff;
               res_in.chunk_end   = chunk_stop;
            end
         end

         lcd_pkg::STATE_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = lcd_pkg::STATE_IDLE;
            end
         end

         default: state_in = lcd_pkg::STATE_IDLE;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcd_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= lcd_pkg::MODE_STATIC;
         min_chunk_ff <= lcd_pkg::CHUNK_BITS'(1);
         workers_ff   <= lcd_pkg::WORKER_BITS'(1);
         first_ff     <= '0;
         limit_ff     <= '0;
         next_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         min_chunk_ff <= min_chunk_in;
         workers_ff   <= workers_in;
         first_ff     <= first_in;
         limit_ff     <= limit_in;
         next_ff      <= next_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      worker_ff <= worker_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### src/lcd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by static and guided claims.
`timescale 1ns / 1ps
`default_nettype none

module lcd_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lcd_pkg::div_req_type div_req,
   output lcd_pkg::div_rsp_type      div_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lcd_pkg::STEP_BITS-1:0]     count_ff, count_in;
   logic [lcd_pkg::INDEX_BITS-1:0]    quot_ff, quot_in;
   logic [lcd_pkg::DIV_BITS-1:0]      rem_ff, rem_in;
   logic [lcd_pkg::DIV_BITS-1:0]      divisor_ff, divisor_in;

   logic [lcd_pkg::DIV_BITS:0]        trial;
   logic [lcd_pkg::DIV_BITS:0]        diff;
   logic                              fits;

   // One trial subtraction per cycle; the dividend shifts out as quotient bits shift in.
   always_comb begin
      trial = {rem_ff, quot_ff[lcd_pkg::INDEX_BITS-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[lcd_pkg::INDEX_BITS-2:0], fits};
         rem_in   = fits ? diff[lcd_pkg::DIV_BITS-1:0] : trial[lcd_pkg::DIV_BITS-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == lcd_pkg::STEP_BITS'(lcd_pkg::INDEX_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

### src/lcd_checker.sv
// Port-level checks for the loop chunk dispenser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module lcd_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire lcd_pkg::req_payload_type req_payload,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire lcd_pkg::rsp_payload_type rsp_payload
);

   // A stalled response stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // Only a granted chunk carries indices.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != lcd_pkg::STATUS_GRANT)
      |-> (rsp_payload.chunk_begin == '0) && (rsp_payload.chunk_end == '0))
      else $error("non-grant response carries chunk indices");

   // A granted chunk is never empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == lcd_pkg::STATUS_GRANT)
      |-> (rsp_payload.chunk_begin < rsp_payload.chunk_end))
      else $error("granted chunk is empty or reversed");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind loop_chunk_dispenser_unit lcd_checker u_lcd_checker (.*);

`default_nettype wire

### sim/loop_chunk_dispenser_unit_test.sv
// Self-checking testbench for the loop chunk dispenser with a scoreboard and random traffic.
`timescale 1ns / 1ps

module loop_chunk_dispenser_unit_test;

   localparam int     CYCLE_LIMIT     = 1000000;
   localparam int     NUM_PHASES      = 12;
   localparam int     ITEMS_PER_PHASE = 128;
   localparam int     SETTLE_CYCLES   = 40;
   localparam longint INDEX_MAX       = 64'sd2147483647;
   localparam longint INDEX_MIN       = -INDEX_MAX - 1;
   localparam logic [lcd_pkg::MODE_BITS-1:0] MODE_RESERVED = 2'd3;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_plan_type;

   // Scoreboard: mirrors the registers and the loop range, predicts each response.
   class chunk_scoreboard;
      lcd_pkg::rsp_payload_type        expected_chunks[$];
      int                              fail_count;
      logic [lcd_pkg::MODE_BITS-1:0]   mode;
      logic [lcd_pkg::CHUNK_BITS-1:0]  chunk_reg;
      logic [6:0]                      workers_reg;
      longint                          range_lo;
      longint                          range_hi;
      longint                          cursor;

      function new();
         fail_count  = 0;
         mode        = lcd_pkg::MODE_STATIC;
         chunk_reg   = lcd_pkg::CHUNK_BITS'(1);
         workers_reg = 7'd1;
         range_lo    = 0;
         range_hi    = 0;
         cursor      = 0;
      endfunction

      function void set_register(lcd_pkg::csr_index_type idx, logic [31:0] value);
         case (idx)
            lcd_pkg::CSR_SCHEDULE_MODE: mode        = value[lcd_pkg::MODE_BITS-1:0];
            lcd_pkg::CSR_MIN_CHUNK:     chunk_reg   = value[lcd_pkg::CHUNK_BITS-1:0];
            lcd_pkg::CSR_WORKER_COUNT:  workers_reg = value[6:0];
            default: ;
         endcase
      endfunction

      // Worker count and chunk size as the block uses them after clamping.
      function longint pool_size();
         if (workers_reg == 0) return 1;
         if (workers_reg > lcd_pkg::MAX_WORKERS) return lcd_pkg::MAX_WORKERS;
         return longint'(workers_reg);
      endfunction

      function longint active_chunk();
         return (chunk_reg == 0) ? 1 : longint'(chunk_reg);
      endfunction

      function lcd_pkg::rsp_payload_type grant(longint b, longint e);
         lcd_pkg::rsp_payload_type r;
         r.status      = lcd_pkg::STATUS_GRANT;
         r.chunk_begin = b[31:0];
         r.chunk_end   = e[31:0];
         return r;
      endfunction

      // Static schedule: an even share, remainder spread over the lowest workers.
      function lcd_pkg::rsp_payload_type static_share(logic [lcd_pkg::ID_BITS-1:0] id);
         lcd_pkg::rsp_payload_type r;
         longint w, total, t, base, extra, offset, count;
         r = '0;
         r.status = lcd_pkg::STATUS_NONE;
         w     = pool_size();
         total = range_hi - range_lo;
         t     = longint'(id);
         if (t >= w || total <= 0) return r;
         base   = total / w;
         extra  = total % w;
         offset = t * base + ((t < extra) ? t : extra);
         count  = base + ((t < extra) ? 1 : 0);
         if (count <= 0) return r;
         return grant(range_lo + offset, range_lo + offset + count);
      endfunction

      // Dynamic and guided schedules take from the shared counter.
      function lcd_pkg::rsp_payload_type shared_chunk(bit guided);
         lcd_pkg::rsp_payload_type r;
         longint b, e, chunk, share;
         r = '0;
         r.status = lcd_pkg::STATUS_NONE;
         b = cursor;
         if (b >= range_hi) return r;
         chunk = active_chunk();
         if (guided) begin
            share = (range_hi - b) / (2 * pool_size());
            if (share > chunk) chunk = share;
         end
         e = b + chunk;
         if (e > range_hi) e = range_hi;
         cursor = e;
         return grant(b, e);
      endfunction

      function void note_request(lcd_pkg::req_payload_type req);
         lcd_pkg::rsp_payload_type r;
         longint s, e;
         r = '0;
         s = longint'($signed(req.range_start));
         e = longint'($signed(req.range_end));
         if (req.op == lcd_pkg::OP_BEGIN) begin
            if (e < s) begin
               r.status = lcd_pkg::STATUS_REJECT;
            end else begin
               range_lo = s;
               range_hi = e;
               cursor   = s;
               r.status = lcd_pkg::STATUS_ACCEPT;
            end
         end else begin
            case (mode)
               lcd_pkg::MODE_STATIC:  r = static_share(req.worker_id);
               lcd_pkg::MODE_DYNAMIC: r = shared_chunk(1'b0);
               lcd_pkg::MODE_GUIDED:  r = shared_chunk(1'b1);
               default:               r.status = lcd_pkg::STATUS_NONE;
            endcase
         end
         expected_chunks.push_back(r);
      endfunction

      task report(string what);
         fail_count++;
         if (fail_count <= 100) $display("mismatch: %s", what);
      endtask

      task check_response(lcd_pkg::rsp_payload_type got);
         lcd_pkg::rsp_payload_type want;
         if (expected_chunks.size() == 0) begin
            report($sformatf("response with nothing pending, status %0d", got.status));
            return;
         end
         want = expected_chunks.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.chunk_begin !== want.chunk_begin)
            report($sformatf("chunk_begin %0d, expected %0d",
                             got.chunk_begin, want.chunk_begin));
         if (got.chunk_end !== want.chunk_end)
            report($sformatf("chunk_end %0d, expected %0d", got.chunk_end, want.chunk_end));
      endtask
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   lcd_pkg::req_payload_type             req_payload;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   lcd_pkg::rsp_payload_type             rsp_payload;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [lcd_pkg::CSR_ADDR_BITS-1:0]    csr_paddr;
   logic [lcd_pkg::CSR_DATA_BITS-1:0]    csr_pwdata;
   logic [lcd_pkg::CSR_DATA_BITS-1:0]    csr_prdata;
   logic                                 csr_pready;

   chunk_scoreboard sb;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              cycle_count = 0;

   loop_chunk_dispenser_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Monitor both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_payload);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_payload);
      end
   end

   // The receiver stalls at random according to the current idling plan.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_stall_pct);
   end

   task set_idling(idle_plan_type plan);
      case (plan)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
         default:       begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task write_register(lcd_pkg::csr_index_type idx, logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Present one request transaction and hold it until accepted. Called at a falling edge.
   task send_request(lcd_pkg::req_payload_type req);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = req;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task send_begin(longint s, longint e);
      lcd_pkg::req_payload_type r;
      r.op          = lcd_pkg::OP_BEGIN;
      r.range_start = s[31:0];
      r.range_end   = e[31:0];
      r.worker_id   = lcd_pkg::ID_BITS'($urandom);
      send_request(r);
   endtask

   task send_claim(int unsigned id);
      lcd_pkg::req_payload_type r;
      r.op          = lcd_pkg::OP_CLAIM;
      r.range_start = $urandom;
      r.range_end   = $urandom;
      r.worker_id   = lcd_pkg::ID_BITS'(id);
      send_request(r);
   endtask

   // Wait until every expected response has come back, with the sender idle.
   task drain();
      req_valid = 1'b0;
      while (sb.expected_chunks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // A begin transaction: mostly short well-formed ranges, some long, rejected or random.
   function automatic lcd_pkg::req_payload_type random_begin();
      lcd_pkg::req_payload_type r;
      longint s, e, span;
      int unsigned kind;
      r.op        = lcd_pkg::OP_BEGIN;
      r.worker_id = lcd_pkg::ID_BITS'($urandom);
      kind        = $urandom_range(99);
      if ($urandom_range(3) == 0) s = longint'($signed($urandom));
      else s = longint'(int'($urandom_range(2000)) - 1000);
      if (kind < 70) begin
         e = s + $urandom_range(300);
      end else if (kind < 85) begin
         e = s + $urandom_range(262143);
      end else if (kind < 92) begin
         span = INDEX_MAX - s;
         e    = s + (longint'({$urandom, $urandom} >> 1) % (span + 1));
      end else if (kind < 98) begin
         if (s == INDEX_MIN) s = s + 1;
         e = INDEX_MIN + (longint'($urandom) % (s - INDEX_MIN));
      end else begin
         s = longint'($signed($urandom));
         e = longint'($signed($urandom));
      end
      if (e > INDEX_MAX) e = INDEX_MAX;
      r.range_start = s[31:0];
      r.range_end   = e[31:0];
      return r;
   endfunction

   initial begin
      logic [15:0] chunk_value;
      logic [6:0]  worker_value;
      logic [1:0]  mode_value;
      int          sent;
      int          claims;

      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      set_idling(IDLE_NONE);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: claims before any begin, full range, out-of-range worker,
      // rejected and empty ranges in static mode at reset settings.
      send_claim(0);
      send_begin(INDEX_MIN, INDEX_MAX);
      send_claim(0);
      send_claim(1);
      send_claim(63);
      send_begin(INDEX_MAX, INDEX_MIN);
      send_begin(5, 5);
      send_claim(0);
      drain();

      // Dynamic with zero chunk size and zero workers, drained to no work.
      write_register(lcd_pkg::CSR_SCHEDULE_MODE, 32'(lcd_pkg::MODE_DYNAMIC));
      write_register(lcd_pkg::CSR_MIN_CHUNK, 32'd0);
      write_register(lcd_pkg::CSR_WORKER_COUNT, 32'd0);
      send_begin(-3, 2);
      repeat (6) send_claim($urandom);
      drain();

      // Largest chunk cut at the top of the index range.
      write_register(lcd_pkg::CSR_MIN_CHUNK, 32'hFFFF);
      send_begin(INDEX_MAX - 10, INDEX_MAX);
      repeat (2) send_claim($urandom);
      drain();

      // Guided with the worker count above the maximum.
      write_register(lcd_pkg::CSR_SCHEDULE_MODE, 32'(lcd_pkg::MODE_GUIDED));
      write_register(lcd_pkg::CSR_WORKER_COUNT, 32'd127);
      send_begin(INDEX_MIN, INDEX_MAX);
      repeat (2) send_claim($urandom);
      drain();

      // Reserved mode answers no work.
      write_register(lcd_pkg::CSR_SCHEDULE_MODE, 32'(MODE_RESERVED));
      send_claim(0);
      drain();

      // Static with empty shares for the upper workers.
      write_register(lcd_pkg::CSR_SCHEDULE_MODE, 32'(lcd_pkg::MODE_STATIC));
      write_register(lcd_pkg::CSR_WORKER_COUNT, 32'd5);
      send_begin(0, 3);
      send_claim(2);
      send_claim(3);
      send_claim(63);
      drain();

      // Random phases: each sets the registers and an idling plan, then runs
      // begin transactions each followed by a burst of claims.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0, 5, 9:  mode_value = lcd_pkg::MODE_STATIC;
            1, 3, 8, 11: mode_value = lcd_pkg::MODE_DYNAMIC;
            6:        mode_value = MODE_RESERVED;
            default:  mode_value = lcd_pkg::MODE_GUIDED;
         endcase
         case (p % 5)
            0:       chunk_value = 16'd1;
            1:       chunk_value = 16'd0;
            2:       chunk_value = 16'hFFFF;
            3:       chunk_value = 16'($urandom_range(40, 2));
            default: chunk_value = 16'($urandom);
         endcase
         case (p % 6)
            0:       worker_value = 7'd1;
            1:       worker_value = 7'd64;
            2:       worker_value = 7'd0;
            3:       worker_value = 7'd127;
            4:       worker_value = 7'($urandom_range(127, 65));
            default: worker_value = 7'($urandom_range(63, 2));
         endcase
         write_register(lcd_pkg::CSR_SCHEDULE_MODE, 32'(mode_value));
         write_register(lcd_pkg::CSR_MIN_CHUNK, 32'(chunk_value));
         write_register(lcd_pkg::CSR_WORKER_COUNT, 32'(worker_value));
         set_idling(idle_plan_type'(p % 4));

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            send_request(random_begin());
            sent++;
            claims = $urandom_range(30, 1);
            for (int c = 0; c < claims; c++) begin
               if ($urandom_range(4) == 0) send_claim($urandom);
               else send_claim($urandom_range(int'(sb.pool_size()) - 1));
               sent++;
            end
         end
         drain();
      end

      // Let any stray response show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.expected_chunks.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
